// ===== hdl/iirl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iirl_pkg
// shared opcodes, status codes and the cell control word of the list unit
// ----------------------------------------------------------------------------
package iirl_pkg;

  localparam int OPCODE_WIDTH = 2;
  localparam int POS_WIDTH    = 5;
  localparam int WORD_WIDTH   = 32;
  localparam int STATUS_WIDTH = 2;
  localparam int COUNT_WIDTH  = 5;

  localparam logic [OPCODE_WIDTH-1:0] OP_APPEND = 2'd0;
  localparam logic [OPCODE_WIDTH-1:0] OP_INSERT = 2'd1;
  localparam logic [OPCODE_WIDTH-1:0] OP_REMOVE = 2'd2;
  localparam logic [OPCODE_WIDTH-1:0] OP_GET    = 2'd3;

  localparam logic [STATUS_WIDTH-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_WIDTH-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_WIDTH-1:0] ST_FULL  = 2'd2;
  localparam logic [STATUS_WIDTH-1:0] ST_EMPTY = 2'd3;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic ins;  // open a slot at the selected position
    logic rem;  // close the slot at the selected position
  } iirl_ctrl_t;

endpackage

// ===== hdl/indexed_insert_remove_list_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_insert_remove_list_unit
// fixed-capacity ordered list with append, insert, remove and get
// ----------------------------------------------------------------------------
// usage
//   input channel: opcode, position, entry_in with in_valid / in_stall
//   output channel: status, entry_out, count_out with out_valid / out_stall
//   every input word yields exactly one output word
//   the registered result word shows in the cycle after the word is taken
//   throughput: one word per cycle while out_stall is low; all chain cells
//     shift at once, so insert and remove finish in the accepting cycle
//   a get or remove reads its entry through a one-hot and-or over all cells
//   in_stall is high only while a result waits and the receiver stalls;
//     the result register then holds its word unchanged
//   reset clears the count and the result valid; entry cells are not
//     cleared, only positions below the count are ever read
//   positions above 31 cannot be addressed; count_out carries the low five
//     bits of the count
// ----------------------------------------------------------------------------
module indexed_insert_remove_list_unit import iirl_pkg::*; #(
  parameter int CAPACITY    = 16,
  parameter int ENTRY_WIDTH = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [OPCODE_WIDTH-1:0] opcode,
  input  logic [POS_WIDTH-1:0]    position,
  input  logic [WORD_WIDTH-1:0]   entry_in,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [STATUS_WIDTH-1:0] status,
  output logic [WORD_WIDTH-1:0]   entry_out,
  output logic [COUNT_WIDTH-1:0]  count_out
);

  // count width, and a compare width that also covers the position field
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > POS_WIDTH) ? CW : POS_WIDTH;
  localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;

  logic          accept;
  logic          is_ins;
  logic [PW-1:0] pos_ext;
  logic [PW-1:0] count_ext;
  logic [PW-1:0] sel_pos;

  logic [STATUS_WIDTH-1:0] st_next;
  logic                    do_ins;
  logic                    do_rem;
  logic                    do_read;
  iirl_ctrl_t              ctrl;

  logic [63:0]             entry_wide;
  logic [ENTRY_WIDTH-1:0]  new_entry;
  logic [ENTRY_WIDTH-1:0]  cell_data [CAPACITY];
  logic [ENTRY_WIDTH-1:0]  cell_rd   [CAPACITY];
  logic [ENTRY_WIDTH-1:0]  rd_word;
  logic [63:0]             rd_wide;
  logic [PW-1:0]           count_out_wide;

  // a result waiting on a stalled receiver blocks the next word
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  assign is_ins    = (opcode == OP_APPEND) || (opcode == OP_INSERT);
  assign pos_ext   = PW'(position);
  assign count_ext = PW'(count);
  // append lands at the tail
  assign sel_pos   = (opcode == OP_APPEND) ? count_ext : pos_ext;

  // status decode; range check of insert comes ahead of the full check
  always_comb begin
    st_next = ST_OK;
    do_ins  = 1'b0;
    do_rem  = 1'b0;
    do_read = 1'b0;
    if (is_ins) begin
      if ((opcode == OP_INSERT) && (pos_ext > count_ext)) begin
        st_next = ST_RANGE;
      end else if (count == FULL_COUNT) begin
        st_next = ST_FULL;
      end else begin
        do_ins = 1'b1;
      end
    end else begin
      if (count == '0) begin
        st_next = ST_EMPTY;
      end else if (pos_ext >= count_ext) begin
        st_next = ST_RANGE;
      end else begin
        do_read = 1'b1;
        do_rem  = (opcode == OP_REMOVE);
      end
    end
  end

  assign ctrl.ins = accept && do_ins;
  assign ctrl.rem = accept && do_rem;

  always_comb begin
    count_next = count;
    if (do_ins) begin
      count_next = count + CW'(1);
    end else if (do_rem) begin
      count_next = count - CW'(1);
    end
  end

  // entry word fitted to the cell width
  assign entry_wide = 64'(entry_in);
  assign new_entry  = entry_wide[ENTRY_WIDTH-1:0];

  // chain of slots, each fed by both neighbors
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ENTRY_WIDTH-1:0] lower;
    logic [ENTRY_WIDTH-1:0] upper;
    if (i == 0) begin : g_first
      assign lower = '0;
    end else begin : g_mid_lo
      assign lower = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign upper = '0;
    end else begin : g_mid_hi
      assign upper = cell_data[i+1];
    end

    iirl_cell #(
      .INDEX       (i),
      .PW          (PW),
      .ENTRY_WIDTH (ENTRY_WIDTH)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .sel_pos   (sel_pos),
      .new_entry (new_entry),
      .lower     (lower),
      .upper     (upper),
      .data      (cell_data[i]),
      .rd        (cell_rd[i])
    );
  end

  // only the selected cell can offer a nonzero word
  always_comb begin
    rd_word = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      rd_word = rd_word | cell_rd[k];
    end
  end

  assign rd_wide        = 64'(rd_word);
  assign count_out_wide = PW'(count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload, loaded only with a fresh word
  always_ff @(posedge clk) begin
    if (accept) begin
      status    <= st_next;
      entry_out <= do_read ? rd_wide[WORD_WIDTH-1:0] : '0;
      count_out <= count_out_wide[COUNT_WIDTH-1:0];
    end
  end

endmodule

// ===== hdl/iirl_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iirl_cell
// one list slot: holds an entry, shifts with its neighbors, offers its word
// ----------------------------------------------------------------------------
module iirl_cell import iirl_pkg::*; #(
  parameter int INDEX       = 0,
  parameter int PW          = 5,
  parameter int ENTRY_WIDTH = 32
) (
  input  logic                   clk,
  input  iirl_ctrl_t             ctrl,
  input  logic [PW-1:0]          sel_pos,
  input  logic [ENTRY_WIDTH-1:0] new_entry,
  input  logic [ENTRY_WIDTH-1:0] lower,
  input  logic [ENTRY_WIDTH-1:0] upper,
  output logic [ENTRY_WIDTH-1:0] data,
  output logic [ENTRY_WIDTH-1:0] rd
);

  localparam logic [PW-1:0] MY_INDEX = PW'(INDEX);

  logic hit;
  logic above;

  assign hit   = (sel_pos == MY_INDEX);
  assign above = (MY_INDEX > sel_pos);

  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (above) begin
        data <= lower;
      end else if (hit) begin
        data <= new_entry;
      end
    end else if (ctrl.rem) begin
      if (above || hit) begin
        data <= upper;
      end
    end
  end

  // masked so the top can or the whole row together
  assign rd = hit ? data : '0;

endmodule
